/* rtl/tkf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_pkg
// Shared constants, state encoding and control bundles of the top-k
// frequent values block.
// ----------------------------------------------------------------------------
`default_nettype none

package tkf_pkg;

   localparam int VALUE_W             = 32;
   localparam int OCC_W               = 16;
   localparam int TOP_COUNT_W         = 7;
   localparam int DEFAULT_TABLE_DEPTH = 64;

   localparam logic [OCC_W-1:0]       OCC_MAX       = {OCC_W{1'b1}};
   localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RST = TOP_COUNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_EMIT
   } tkf_state_type;

   // One result handed from the sequencer to the output register.
   typedef struct packed {
      logic                      load;
      logic signed [VALUE_W-1:0] value;
      logic [OCC_W-1:0]          count;
      logic                      overflow;
      logic                      last;
   } tkf_emit_type;

   typedef struct packed {
      logic idle;
      logic empty;
   } tkf_status_type;

endpackage

`default_nettype wire

/* rtl/tkf_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_table
// Value and count storage: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tkf_table #(
   parameter int TABLE_DEPTH = tkf_pkg::DEFAULT_TABLE_DEPTH,
   parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                              clock,
   input  wire logic [IDX_W-1:0]                  wr_addr,
   input  wire logic                              wr_val_en,
   input  wire logic                              wr_cnt_en,
   input  wire logic signed [tkf_pkg::VALUE_W-1:0] wr_val,
   input  wire logic [tkf_pkg::OCC_W-1:0]         wr_cnt,
   input  wire logic                              rd_en,
   input  wire logic [IDX_W-1:0]                  rd_addr,
   output logic signed [tkf_pkg::VALUE_W-1:0]     rd_val,
   output logic [tkf_pkg::OCC_W-1:0]              rd_cnt
);
   import tkf_pkg::*;

   logic signed [VALUE_W-1:0] val_mem [TABLE_DEPTH];
   logic [OCC_W-1:0]          cnt_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_val_en) begin
         val_mem[wr_addr] <= wr_val;
      end
      if (wr_cnt_en) begin
         cnt_mem[wr_addr] <= wr_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_val <= val_mem[rd_addr];
         rd_cnt <= cnt_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/tkf_cmp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_cmp_unit
// Shared compare unit: value equality for the lookup, rank order for the
// selection (higher count first, then larger signed value).
// ----------------------------------------------------------------------------
`default_nettype none

module tkf_cmp_unit (
   input  wire logic [tkf_pkg::OCC_W-1:0]          a_cnt,
   input  wire logic signed [tkf_pkg::VALUE_W-1:0] a_val,
   input  wire logic [tkf_pkg::OCC_W-1:0]          b_cnt,
   input  wire logic signed [tkf_pkg::VALUE_W-1:0] b_val,
   output logic                                    val_eq,
   output logic                                    ahead
);
   import tkf_pkg::*;

   always_comb begin
      val_eq = (a_val == b_val);
      ahead  = (a_cnt > b_cnt) || ((a_cnt == b_cnt) && (a_val > b_val));
   end

endmodule

`default_nettype wire

/* rtl/tkf_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_seq
// Sequencer: walks the table once per beat to find or insert the value,
// then walks it once per result to pick the next best entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tkf_seq #(
   parameter int TABLE_DEPTH = tkf_pkg::DEFAULT_TABLE_DEPTH,
   parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [tkf_pkg::VALUE_W-1:0] req_value,
   input  wire logic                               req_last_item,
   input  wire logic [tkf_pkg::TOP_COUNT_W-1:0]    top_count,
   input  wire logic                               slot_free,
   output tkf_pkg::tkf_emit_type                   emit,
   output tkf_pkg::tkf_status_type                 status,
   output logic [IDX_W-1:0]                        tbl_wr_addr,
   output logic                                    tbl_wr_val_en,
   output logic                                    tbl_wr_cnt_en,
   output logic signed [tkf_pkg::VALUE_W-1:0]      tbl_wr_val,
   output logic [tkf_pkg::OCC_W-1:0]               tbl_wr_cnt,
   output logic                                    tbl_rd_en,
   output logic [IDX_W-1:0]                        tbl_rd_addr,
   input  wire logic signed [tkf_pkg::VALUE_W-1:0] tbl_rd_val,
   input  wire logic [tkf_pkg::OCC_W-1:0]          tbl_rd_cnt
);
   import tkf_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   tkf_state_type state_ff, state_in;

   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                      last_ff, last_in;
   logic [CNT_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]          used_ff, used_in;
   logic                      ovf_ff, ovf_in;
   logic [TABLE_DEPTH-1:0]    taken_ff, taken_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic                      best_vld_ff, best_vld_in;
   logic signed [VALUE_W-1:0] best_val_ff, best_val_in;
   logic [OCC_W-1:0]          best_cnt_ff, best_cnt_in;
   logic [IDX_W-1:0]          best_idx_ff, best_idx_in;

   logic                      issue;
   logic                      scan_hit;
   logic                      scan_done;
   logic                      pick_done;
   logic                      tbl_full;
   logic                      emit_go;
   logic                      emit_last;
   logic [TOP_COUNT_W-1:0]    top_eff;
   logic [CNT_W-1:0]          want;
   logic [OCC_W-1:0]          cnt_sat;
   logic [OCC_W-1:0]          cmp_b_cnt;
   logic signed [VALUE_W-1:0] cmp_b_val;
   logic                      cmp_eq;
   logic                      cmp_ahead;

   // During the lookup the entry is matched against the incoming value;
   // during selection it is ranked against the best entry so far.
   assign cmp_b_cnt = best_cnt_ff;
   assign cmp_b_val = (state_ff == ST_SCAN) ? val_ff : best_val_ff;

   tkf_cmp_unit u_cmp (
      .a_cnt  (tbl_rd_cnt),
      .a_val  (tbl_rd_val),
      .b_cnt  (cmp_b_cnt),
      .b_val  (cmp_b_val),
      .val_eq (cmp_eq),
      .ahead  (cmp_ahead)
   );

   always_comb begin
      issue     = ((state_ff == ST_SCAN) || (state_ff == ST_PICK)) && (rd_idx_ff < used_ff);
      scan_hit  = (state_ff == ST_SCAN) && rd_vld_ff && cmp_eq;
      scan_done = (state_ff == ST_SCAN) && !rd_vld_ff && !issue;
      pick_done = (state_ff == ST_PICK) && !rd_vld_ff && !issue;
      tbl_full  = (used_ff == DEPTH_CNT);
      emit_go   = (state_ff == ST_EMIT) && slot_free;
      top_eff   = (top_count == '0) ? TOP_COUNT_RST : top_count;
      want      = (top_eff > TOP_COUNT_W'(used_ff)) ? used_ff : top_eff[CNT_W-1:0];
      emit_last = ((k_ff + CNT_W'(1)) == want);
      cnt_sat   = (tbl_rd_cnt == OCC_MAX) ? tbl_rd_cnt : tbl_rd_cnt + OCC_W'(1);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_done) begin
               state_in = last_ff ? ST_PICK : ST_IDLE;
            end
         end
         ST_PICK: begin
            if (pick_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               state_in = emit_last ? ST_IDLE : ST_PICK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      tbl_rd_en      = issue;
      tbl_rd_addr    = rd_idx_ff[IDX_W-1:0];
      tbl_wr_addr    = cmp_idx_ff;
      tbl_wr_val_en  = 1'b0;
      tbl_wr_cnt_en  = 1'b0;
      tbl_wr_val     = val_ff;
      tbl_wr_cnt     = cnt_sat;
      if (scan_hit) begin
         tbl_wr_cnt_en = 1'b1;
      end else if (scan_done && !tbl_full) begin
         tbl_wr_addr   = used_ff[IDX_W-1:0];
         tbl_wr_val_en = 1'b1;
         tbl_wr_cnt_en = 1'b1;
         tbl_wr_cnt    = OCC_W'(1);
      end
      emit.load     = emit_go;
      emit.value    = best_val_ff;
      emit.count    = best_cnt_ff;
      emit.overflow = ovf_ff;
      emit.last     = emit_last;
      status.idle   = (state_ff == ST_IDLE);
      status.empty  = (used_ff == '0) && !ovf_ff;
   end

   // Datapath next values.
   always_comb begin
      val_in      = val_ff;
      last_in     = last_ff;
      rd_idx_in   = rd_idx_ff;
      rd_vld_in   = rd_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      used_in     = used_ff;
      ovf_in      = ovf_ff;
      taken_in    = taken_ff;
      k_in        = k_ff;
      best_vld_in = best_vld_ff;
      best_val_in = best_val_ff;
      best_cnt_in = best_cnt_ff;
      best_idx_in = best_idx_ff;

      if ((state_ff == ST_SCAN) || (state_ff == ST_PICK)) begin
         rd_vld_in  = issue;
         cmp_idx_in = rd_idx_ff[IDX_W-1:0];
         if (issue) begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in    = req_value;
               last_in   = req_last_item;
               rd_idx_in = '0;
               rd_vld_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (tbl_full) begin
                  ovf_in = 1'b1;
               end else begin
                  used_in = used_ff + CNT_W'(1);
               end
            end
            if (scan_hit || scan_done) begin
               rd_idx_in   = '0;
               rd_vld_in   = 1'b0;
               best_vld_in = 1'b0;
               k_in        = '0;
            end
         end
         ST_PICK: begin
            if (rd_vld_ff && !taken_ff[cmp_idx_ff] && (!best_vld_ff || cmp_ahead)) begin
               best_vld_in = 1'b1;
               best_val_in = tbl_rd_val;
               best_cnt_in = tbl_rd_cnt;
               best_idx_in = cmp_idx_ff;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               taken_in[best_idx_ff] = 1'b1;
               k_in        = k_ff + CNT_W'(1);
               rd_idx_in   = '0;
               rd_vld_in   = 1'b0;
               best_vld_in = 1'b0;
               if (emit_last) begin
                  used_in  = '0;
                  ovf_in   = 1'b0;
                  taken_in = '0;
               end
            end
         end
         default: begin
            rd_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_vld_ff   <= 1'b0;
         used_ff     <= '0;
         ovf_ff      <= 1'b0;
         taken_ff    <= '0;
         k_ff        <= '0;
         best_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= rd_vld_in;
         used_ff     <= used_in;
         ovf_ff      <= ovf_in;
         taken_ff    <= taken_in;
         k_ff        <= k_in;
         best_vld_ff <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      last_ff     <= last_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_val_ff <= best_val_in;
      best_cnt_ff <= best_cnt_in;
      best_idx_ff <= best_idx_in;
   end

endmodule

`default_nettype wire

/* rtl/top_k_frequent_values.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_frequent_values
// Counts the distinct values of a set and, after the final beat, returns the
// most frequent ones, highest count first and larger value first on ties.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_ready | req_value, req_last_item
//   rsp     | out       | rsp_valid / rsp_ready | rsp_top_value, rsp_occurrences,
//           |           |                       | rsp_table_overflow, rsp_last_result
//   csr     | in        | csr_valid / csr_ready | csr_top_count
//
// A request beat holds the block until its lookup ends: the lookup reads the held
// distinct values one entry a cycle through the single read port, and a hit ends the
// walk early. After the final beat each result takes a full walk through the same port
// and the shared compare unit, then the emit state hands it to the output register.
// Reset is synchronous and needs no clearing pass. A stalled response holds the next
// hand-off back; request beats wait on it only while results of the set remain.
`default_nettype none

module top_k_frequent_values #(
   parameter int TABLE_DEPTH = tkf_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [tkf_pkg::VALUE_W-1:0] req_value,
   input  wire logic                               req_last_item,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [tkf_pkg::VALUE_W-1:0]      rsp_top_value,
   output logic [tkf_pkg::OCC_W-1:0]               rsp_occurrences,
   output logic                                    rsp_table_overflow,
   output logic                                    rsp_last_result,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tkf_pkg::TOP_COUNT_W-1:0]    csr_top_count
);
   import tkf_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Configuration register: the number of results per set.
   logic [TOP_COUNT_W-1:0] top_count_ff, top_count_in;

   // Output register, which decouples the sequencer from the response side.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [OCC_W-1:0]          rsp_occ_ff;
   logic                      rsp_ovf_ff;
   logic                      rsp_last_ff;
   logic                      slot_free;

   tkf_emit_type   emit;
   tkf_status_type status;

   logic [IDX_W-1:0]          tbl_wr_addr;
   logic                      tbl_wr_val_en;
   logic                      tbl_wr_cnt_en;
   logic signed [VALUE_W-1:0] tbl_wr_val;
   logic [OCC_W-1:0]          tbl_wr_cnt;
   logic                      tbl_rd_en;
   logic [IDX_W-1:0]          tbl_rd_addr;
   logic signed [VALUE_W-1:0] tbl_rd_val;
   logic [OCC_W-1:0]          tbl_rd_cnt;

   tkf_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock     (clock),
      .wr_addr   (tbl_wr_addr),
      .wr_val_en (tbl_wr_val_en),
      .wr_cnt_en (tbl_wr_cnt_en),
      .wr_val    (tbl_wr_val),
      .wr_cnt    (tbl_wr_cnt),
      .rd_en     (tbl_rd_en),
      .rd_addr   (tbl_rd_addr),
      .rd_val    (tbl_rd_val),
      .rd_cnt    (tbl_rd_cnt)
   );

   tkf_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_last_item (req_last_item),
      .top_count     (top_count_ff),
      .slot_free     (slot_free),
      .emit          (emit),
      .status        (status),
      .tbl_wr_addr   (tbl_wr_addr),
      .tbl_wr_val_en (tbl_wr_val_en),
      .tbl_wr_cnt_en (tbl_wr_cnt_en),
      .tbl_wr_val    (tbl_wr_val),
      .tbl_wr_cnt    (tbl_wr_cnt),
      .tbl_rd_en     (tbl_rd_en),
      .tbl_rd_addr   (tbl_rd_addr),
      .tbl_rd_val    (tbl_rd_val),
      .tbl_rd_cnt    (tbl_rd_cnt)
   );

   // Always writable; users must write only while the block idles; not enforced.
   assign csr_ready = 1'b1;

   // The output slot can take a new result when it is empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      top_count_in = top_count_ff;
      if (csr_valid) begin
         top_count_in = csr_top_count;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= TOP_COUNT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_count_ff <= top_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.load) begin
         rsp_value_ff <= emit.value;
         rsp_occ_ff   <= emit.count;
         rsp_ovf_ff   <= emit.overflow;
         rsp_last_ff  <= emit.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_top_value      = rsp_value_ff;
   assign rsp_occurrences    = rsp_occ_ff;
   assign rsp_table_overflow = rsp_ovf_ff;
   assign rsp_last_result    = rsp_last_ff;

   // Once the final result of a set is handed off, the sequencer is idle
   // with an empty table and a cleared overflow flag.
   assert property (@(posedge clock) disable iff (reset)
      emit.load && emit.last |=> status.idle && status.empty)
      else $error("table not cleared after the final result of a set");

   // A new result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      emit.load |-> !rsp_valid_ff || rsp_ready)
      else $error("result loaded into an occupied output register");

   // The block works on one request beat at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous beat is still in work");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for top_k_frequent_values. A queue of pending set beats
// feeds a clocked driver; a clocked monitor predicts the ranked results of
// every accepted beat and checks each response beat against them.
// ----------------------------------------------------------------------------

module tb;

   import tkf_pkg::*;

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;

   // After the final response of a phase the sequencer may still be returning
   // to idle; the settle wait is longer than one table walk.
   localparam int SETTLE_CYCLES = DEPTH + 8;

   // Minimum number of random beats to send after the directed sets.
   localparam int RANDOM_BEATS = 350;

   // One beat of the request channel as it waits in the send queue.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last_item;
   } set_beat_type;

   // One ranked value as the response channel should return it.
   typedef struct packed {
      logic signed [VALUE_W-1:0] top_value;
      logic [OCC_W-1:0]          occurrences;
      logic                      table_overflow;
      logic                      last_result;
   } ranked_value_type;

   logic                       clock;
   logic                       reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       req_last_item = 1'b0;

   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_top_value;
   logic [OCC_W-1:0]           rsp_occurrences;
   logic                       rsp_table_overflow;
   logic                       rsp_last_result;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [TOP_COUNT_W-1:0]     csr_top_count = '0;

   // Beats waiting to be sent and ranked values waiting to be returned.
   set_beat_type               pending_beats[$];
   ranked_value_type           expected_ranks[$];

   // Shadow of the block: the distinct-value table and the top_count register.
   logic signed [VALUE_W-1:0]  tally_values[DEPTH];
   logic [OCC_W-1:0]           tally_counts[DEPTH];
   int                         tally_used = 0;
   logic                       tally_overflow = 1'b0;
   logic [TOP_COUNT_W-1:0]     rank_limit = TOP_COUNT_RST;

   // Handshake bookkeeping shared between the monitor and the drivers.
   bit                         req_beat_taken = 1'b0;
   bit                         rsp_beat_taken = 1'b0;
   int                         req_gap_left = 0;
   int                         rsp_stall_left = 0;
   bit                         req_calm = 1'b0;
   bit                         rsp_calm = 1'b0;

   int                         mismatch_count = 0;
   int                         random_sent = 0;
   int                         set_beats;
   ranked_value_type           want_rank;
   set_beat_type               next_beat;

   top_k_frequent_values #(
      .TABLE_DEPTH (DEPTH)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_value          (req_value),
      .req_last_item      (req_last_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_top_value      (rsp_top_value),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_table_overflow (rsp_table_overflow),
      .rsp_last_result    (rsp_last_result),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_top_count      (csr_top_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Counts one accepted value into the shadow table. On the final beat of a
   // set it ranks the table, queues the ranked values and empties the table.
   function automatic void tally_value(input logic signed [VALUE_W-1:0] value,
                                       input logic last_item);
      int               hit;
      int               want;
      int               best;
      logic [DEPTH-1:0] taken;
      ranked_value_type ranked;
      hit = -1;
      for (int i = 0; i < tally_used; i++)
         if (hit < 0 && tally_values[i] == value) hit = i;
      if (hit >= 0) begin
         // A count pinned at its maximum stays there.
         if (tally_counts[hit] != OCC_MAX) tally_counts[hit]++;
      end else if (tally_used < DEPTH) begin
         tally_values[tally_used] = value;
         tally_counts[tally_used] = OCC_W'(1);
         tally_used++;
      end else begin
         // Table full: the new value is lost, but the set is flagged.
         tally_overflow = 1'b1;
      end
      if (!last_item) return;

      // A top_count of zero still yields one result; a count above the number
      // of entries yields every entry.
      want = (rank_limit == 0) ? 1 : int'(rank_limit);
      if (want > tally_used) want = tally_used;
      taken = '0;
      for (int k = 0; k < want; k++) begin
         best = -1;
         for (int i = 0; i < tally_used; i++) begin
            if (taken[i]) continue;
            // Higher count wins; on equal counts the larger signed value wins.
            if (best < 0 || tally_counts[i] > tally_counts[best] ||
                (tally_counts[i] == tally_counts[best] &&
                 tally_values[i] > tally_values[best]))
               best = i;
         end
         taken[best]           = 1'b1;
         ranked.top_value      = tally_values[best];
         ranked.occurrences    = tally_counts[best];
         ranked.table_overflow = tally_overflow;
         ranked.last_result    = (k == want - 1);
         expected_ranks        = {expected_ranks, ranked};
      end
      tally_used     = 0;
      tally_overflow = 1'b0;
   endfunction

   task automatic queue_beat(input logic signed [VALUE_W-1:0] value,
                             input logic last_item);
      set_beat_type beat;
      beat.value     = value;
      beat.last_item = last_item;
      pending_beats  = {pending_beats, beat};
   endtask

   // Waits until every queued beat has gone out and every ranked value has
   // come back, then lets the sequencer settle. Checked on the rising edge,
   // where the driver never has a beat popped but not yet presented.
   task automatic wait_for_idle();
      do @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_ranks.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_top_count(input logic [TOP_COUNT_W-1:0] limit);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_top_count <= limit;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      rank_limit = limit;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Queues one random set. Most sets are short and drawn from a small pool
   // of values so that counts and ties build up; a few are long and mostly
   // fresh values, which can fill the table and overflow it.
   task automatic queue_random_set(output int count);
      logic signed [VALUE_W-1:0] pool[8];
      logic signed [VALUE_W-1:0] value;
      int                        pool_size;
      bit                        wide;
      wide      = ($urandom_range(0, 9) == 0);
      count     = wide ? $urandom_range(20, 72) : $urandom_range(1, 10);
      pool_size = $urandom_range(1, 8);
      foreach (pool[p]) begin
         case ($urandom_range(0, 3))
            0: begin
               case ($urandom_range(0, 3))
                  0:       pool[p] = 32'sh8000_0000;
                  1:       pool[p] = 32'sh7FFF_FFFF;
                  2:       pool[p] = '0;
                  default: pool[p] = '1;
               endcase
            end
            1:       pool[p] = $signed(VALUE_W'($urandom_range(0, 15))) - 8;
            default: pool[p] = $urandom();
         endcase
      end
      for (int k = 0; k < count; k++) begin
         if (wide && $urandom_range(0, 3) != 0) value = $urandom();
         else value = pool[$urandom_range(0, pool_size - 1)];
         queue_beat(value, k == count - 1);
      end
   endtask

   // Request driver. A new beat is presented only once the previous one was
   // taken and the drawn gap has run out; valid is written once per step.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_taken) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            next_beat      = pending_beats.pop_front();
            req_value     <= next_beat.value;
            req_last_item <= next_beat.last_item;
            req_valid     <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response sink. After each beat a stall is drawn; it only runs down while
   // a response is actually offered, so stalls land on waiting results.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_beat_taken) begin
            if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
            rsp_stall_left = rsp_calm ? 0 : $urandom_range(0, 5);
         end
         if (rsp_stall_left > 0) begin
            rsp_ready <= 1'b0;
            if (rsp_valid) rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: predicts on every accepted request beat and checks every
   // accepted response beat against the oldest ranked value waiting.
   always @(posedge clock) begin
      req_beat_taken = 1'b0;
      rsp_beat_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_beat_taken = 1'b1;
            tally_value(req_value, req_last_item);
            if ($urandom_range(0, 29) == 0) req_calm = !req_calm;
            req_gap_left = req_calm ? 0 : $urandom_range(0, 5);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_beat_taken = 1'b1;
            if (expected_ranks.size() == 0) begin
               $error("unexpected rsp beat: top_value %0d, occurrences %0d",
                      rsp_top_value, rsp_occurrences);
               mismatch_count++;
            end else begin
               want_rank = expected_ranks.pop_front();
               if (rsp_top_value !== want_rank.top_value) begin
                  $error("top_value: expected %0d, got %0d",
                         want_rank.top_value, rsp_top_value);
                  mismatch_count++;
               end
               if (rsp_occurrences !== want_rank.occurrences) begin
                  $error("occurrences: expected %0d, got %0d",
                         want_rank.occurrences, rsp_occurrences);
                  mismatch_count++;
               end
               if (rsp_table_overflow !== want_rank.table_overflow) begin
                  $error("table_overflow: expected %0b, got %0b",
                         want_rank.table_overflow, rsp_table_overflow);
                  mismatch_count++;
               end
               if (rsp_last_result !== want_rank.last_result) begin
                  $error("last_result: expected %0b, got %0b",
                         want_rank.last_result, rsp_last_result);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Main sequence: reset, directed sets, the table-full set, then random
   // phases, each phase opening with a fresh top_count.
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The reset top_count of one: only the winner of a tie between the
      // largest positive value and minus one comes back.
      queue_beat(32'sh8000_0000, 1'b0);
      queue_beat(32'sh7FFF_FFFF, 1'b0);
      queue_beat('0, 1'b0);
      queue_beat('1, 1'b0);
      queue_beat(32'sh7FFF_FFFF, 1'b0);
      queue_beat('1, 1'b1);
      wait_for_idle();

      // A top_count equal to the table depth: more than the entries held, so all return.
      write_top_count(TOP_COUNT_W'(64));
      queue_beat(32'sh5555_5555, 1'b1);
      queue_beat(-5, 1'b0);
      queue_beat(-5, 1'b0);
      queue_beat(3, 1'b0);
      queue_beat(3, 1'b0);
      queue_beat(-7, 1'b0);
      queue_beat(7, 1'b0);
      queue_beat(7, 1'b0);
      queue_beat(7, 1'b1);
      wait_for_idle();

      // A top_count of zero behaves as one.
      write_top_count('0);
      queue_beat(32'shAAAA_AAAA, 1'b0);
      queue_beat(32'sh8000_0000, 1'b1);
      wait_for_idle();

      // All ones in the register.
      write_top_count('1);
      queue_beat(32'sh0F0F_0F0F, 1'b0);
      queue_beat(32'shF0F0_F0F0, 1'b0);
      queue_beat(32'sh0F0F_0F0F, 1'b1);
      wait_for_idle();

      // Table full: once every entry is taken, held values still count, new
      // values are dropped, and the final beat itself is a dropped value.
      write_top_count(TOP_COUNT_W'(DEPTH));
      for (int i = 0; i < DEPTH; i++)
         queue_beat(VALUE_W'(i * 1000003 - 31000000), 1'b0);
      queue_beat(VALUE_W'(5 * 1000003 - 31000000), 1'b0);
      queue_beat(32'sh7FFF_FFFF, 1'b0);
      queue_beat(VALUE_W'(5 * 1000003 - 31000000), 1'b0);
      queue_beat(32'sh8000_0000, 1'b0);
      queue_beat(32'sh1234_5678, 1'b1);
      wait_for_idle();

      while (random_sent < RANDOM_BEATS) begin
         case ($urandom_range(0, 7))
            0:       write_top_count('0);
            1:       write_top_count('1);
            2:       write_top_count(TOP_COUNT_W'(DEPTH));
            3:       write_top_count(TOP_COUNT_W'(1));
            default: write_top_count(TOP_COUNT_W'($urandom_range(2, 12)));
         endcase
         // Sets within a phase go back to back, so the next set's beats meet
         // the block while it is still returning the previous ranking.
         repeat ($urandom_range(2, 5)) begin
            queue_random_set(set_beats);
            random_sent += set_beats;
         end
         wait_for_idle();
      end

      if (mismatch_count == 0 && expected_ranks.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Watchdog: the slowest correct run, with every beat and every result
   // paying a full table walk and every stall at its longest, stays far
   // below this.
   initial begin
      #10_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

/* sim.f */
rtl/tkf_pkg.sv
rtl/tkf_table.sv
rtl/tkf_cmp_unit.sv
rtl/tkf_seq.sv
rtl/top_k_frequent_values.sv
tb/tb.sv
